// File: rtl/core/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants of the binomial coefficient unit
// Widths, result codes, controller states and the command and status
// structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam int N_W      = 6;              // width of n and k
  localparam int COEF_W   = 32;             // width of the coefficient
  localparam int PROD_W   = COEF_W + N_W;   // running value times a factor
  localparam int STAT_W   = 2;
  localparam int MAX_N    = 34;             // largest n that is served
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_K_GT_N = 2'd1,
    STAT_SAT    = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_ACC,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture n and k, classify
    logic mul;       // product = acc * (base + i)
    logic div_step;  // one restoring division bit
    logic acc;       // acc = quotient, advance i
    logic emit;      // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early;     // no iteration needed
    logic div_last;  // last quotient bit this cycle
    logic iter_last; // last factor
    logic over;      // quotient above the coefficient range
  } sts_t;

endpackage

// File: rtl/core/bc_dpath.sv
// ----------------------------------------------------------------------------
// bc_dpath: datapath of the binomial coefficient unit
// Running value, one 32x6 multiplier and a bit-serial exact divider.
// ----------------------------------------------------------------------------
module bc_dpath (
  input  logic                          clk,
  input  bc_pkg::cmd_t                  cmd,
  output bc_pkg::sts_t                  sts,
  input  logic [bc_pkg::N_W-1:0]        n_total,
  input  logic [bc_pkg::N_W-1:0]        k_choose,
  output logic [bc_pkg::COEF_W-1:0]     coefficient,
  output logic [bc_pkg::STAT_W-1:0]     status
);

  logic [bc_pkg::COEF_W-1:0] acc_r, acc_nxt;
  logic [bc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [bc_pkg::N_W-1:0]    rem_r, rem_nxt;
  logic [bc_pkg::N_W-1:0]    cnt_r, cnt_nxt;
  logic [bc_pkg::N_W-1:0]    i_r, i_nxt;
  logic [bc_pkg::N_W-1:0]    m_r, m_nxt;
  logic [bc_pkg::N_W-1:0]    base_r, base_nxt;
  bc_pkg::stat_t             stat_r, stat_nxt;
  logic [bc_pkg::COEF_W-1:0] coef_r, coef_nxt;
  bc_pkg::stat_t             ostat_r, ostat_nxt;

  logic [bc_pkg::N_W-1:0]    diff;
  logic [bc_pkg::N_W-1:0]    fac;
  logic [bc_pkg::PROD_W-1:0] mul_w;
  logic [bc_pkg::N_W:0]      rem_sh;
  logic                      q_bit;

  assign diff   = n_total - k_choose;
  assign fac    = bc_pkg::N_W'(base_r + i_r);
  assign mul_w  = bc_pkg::PROD_W'(acc_r) * bc_pkg::PROD_W'(fac);
  assign rem_sh = {rem_r, prod_r[bc_pkg::PROD_W-1]};
  assign q_bit  = rem_sh >= {1'b0, i_r};

  assign sts.early     = (stat_r != bc_pkg::STAT_OK) || (m_r == '0);
  assign sts.div_last  = cnt_r == bc_pkg::N_W'(bc_pkg::PROD_W - 1);
  assign sts.iter_last = i_r == m_r;
  assign sts.over      = prod_r[bc_pkg::PROD_W-1:bc_pkg::COEF_W] != '0;

  always_comb begin
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    m_nxt     = m_r;
    base_nxt  = base_r;
    stat_nxt  = stat_r;
    coef_nxt  = coef_r;
    ostat_nxt = ostat_r;
    if (cmd.load) begin
      m_nxt    = (diff < k_choose) ? diff : k_choose;
      base_nxt = n_total - m_nxt;
      i_nxt    = bc_pkg::N_W'(1);
      if (k_choose > n_total) begin
        stat_nxt = bc_pkg::STAT_K_GT_N;
        acc_nxt  = '0;
      end else if (n_total > bc_pkg::N_W'(bc_pkg::MAX_N)) begin
        stat_nxt = bc_pkg::STAT_SAT;
        acc_nxt  = '1;
      end else begin
        stat_nxt = bc_pkg::STAT_OK;
        acc_nxt  = bc_pkg::COEF_W'(1);
      end
    end
    if (cmd.mul) begin
      prod_nxt = mul_w;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end
    if (cmd.div_step) begin
      prod_nxt = {prod_r[bc_pkg::PROD_W-2:0], q_bit};
      rem_nxt  = q_bit ? bc_pkg::N_W'(rem_sh - {1'b0, i_r}) : rem_sh[bc_pkg::N_W-1:0];
      cnt_nxt  = cnt_r + bc_pkg::N_W'(1);
    end
    if (cmd.acc) begin
      i_nxt = i_r + bc_pkg::N_W'(1);
      if (sts.over) begin
        acc_nxt  = '1;
        stat_nxt = bc_pkg::STAT_SAT;
      end else begin
        acc_nxt = prod_r[bc_pkg::COEF_W-1:0];
      end
    end
    if (cmd.emit) begin
      coef_nxt  = acc_r;
      ostat_nxt = stat_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    i_r     <= i_nxt;
    m_r     <= m_nxt;
    base_r  <= base_nxt;
    stat_r  <= stat_nxt;
    coef_r  <= coef_nxt;
    ostat_r <= ostat_nxt;
  end

  assign coefficient = coef_r;
  assign status      = ostat_r;

endmodule

// File: rtl/core/bc_ctrl.sv
// ----------------------------------------------------------------------------
// bc_ctrl: controller of the binomial coefficient unit
// Sequences accept, classify, multiply / divide iterations and result hand-off.
// ----------------------------------------------------------------------------
module bc_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  output bc_pkg::cmd_t cmd,
  input  bc_pkg::sts_t sts
);

  bc_pkg::state_t state_r, state_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic           out_free;

  assign out_free = !ovalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bc_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = bc_pkg::S_CHECK;
        end
      end
      bc_pkg::S_CHECK: begin
        state_nxt = sts.early ? bc_pkg::S_DONE : bc_pkg::S_MUL;
      end
      bc_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = bc_pkg::S_DIV;
      end
      bc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = bc_pkg::S_ACC;
        end
      end
      bc_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = (sts.over || sts.iter_last) ? bc_pkg::S_DONE : bc_pkg::S_MUL;
      end
      bc_pkg::S_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = bc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

// File: rtl/core/binomial_coefficient.sv
// ----------------------------------------------------------------------------
// binomial_coefficient: n-choose-k unit
// Returns C(n,k) for 6-bit n and k, with error and saturation status.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The unit works on one item at a
// time: it runs up to min(k, n-k) iterations of multiply, exact division
// by i and accumulate, paced by the single 32x6 multiplier and the
// bit-serial divider. k > n returns coefficient 0 with status 1 without
// iterating; otherwise n above 34 returns all ones with status 2.
// The result sits in an output register, so the result transaction may be
// stalled; the next input is taken once the current result is handed off to
// that register.
module binomial_coefficient (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] n_total, [11:6] k_choose, [15:12] zero
  input  logic [bc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] coefficient, [33:32] status, [39:34] zero
  output logic [bc_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  bc_pkg::cmd_t              cmd;
  bc_pkg::sts_t              sts;
  logic [bc_pkg::COEF_W-1:0] coefficient;
  logic [bc_pkg::STAT_W-1:0] status;

  bc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  bc_dpath u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .n_total     (in_tdata[bc_pkg::N_W-1:0]),
    .k_choose    (in_tdata[2*bc_pkg::N_W-1:bc_pkg::N_W]),
    .coefficient (coefficient),
    .status      (status)
  );

  // pad to whole bytes
  assign out_tdata = {
    (bc_pkg::OUT_TDATA_W - bc_pkg::COEF_W - bc_pkg::STAT_W)'(0),
    status,
    coefficient
  };

endmodule

// File: rtl/core/bc_chk.sv
// ----------------------------------------------------------------------------
// bc_chk: port checker for binomial_coefficient
// Watches the stream ports and the result codes over time.
// ----------------------------------------------------------------------------
module bc_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [bc_pkg::STAT_W-1:0] stat;
  logic [bc_pkg::COEF_W-1:0] coef;

  assign stat = out_tdata[bc_pkg::COEF_W +: bc_pkg::STAT_W];
  assign coef = out_tdata[bc_pkg::COEF_W-1:0];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (stat == bc_pkg::STAT_K_GT_N) |-> coef == '0)
    else $error("k > n result not zero");

  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (stat == bc_pkg::STAT_SAT) |-> coef == '1)
    else $error("saturated result not all ones");

  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (stat == bc_pkg::STAT_OK) || (stat == bc_pkg::STAT_K_GT_N) ||
                   (stat == bc_pkg::STAT_SAT))
    else $error("undefined status code");

endmodule

bind binomial_coefficient bc_chk u_bc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/bc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_checker: result checker for the binomial coefficient unit
// Snoops both stream channels, predicts C(n,k) with status for every input
// transaction and compares each result transaction, in order, field by field.
// ----------------------------------------------------------------------------
module bc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [bc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [bc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                             fail_cnt,
  output int                             pending_cnt,
  output int                             results_seen
);

  typedef struct packed {
    logic [bc_pkg::COEF_W-1:0] coef;
    bc_pkg::stat_t             stat;
  } choose_res_t;

  choose_res_t coef_q[$];

  // C(n,k) over the smaller of k and n-k; every division is exact
  function automatic choose_res_t choose_predict(input logic [bc_pkg::N_W-1:0] n,
                                                 input logic [bc_pkg::N_W-1:0] k);
    choose_res_t res;
    logic [63:0] run;
    int unsigned nn, kk, m, i;
    nn = n;
    kk = k;
    res.coef = '0;
    res.stat = bc_pkg::STAT_OK;
    if (kk > nn) begin
      res.stat = bc_pkg::STAT_K_GT_N;
    end else if (nn > bc_pkg::MAX_N) begin
      res.coef = '1;
      res.stat = bc_pkg::STAT_SAT;
    end else begin
      m   = (nn - kk < kk) ? nn - kk : kk;
      run = 64'd1;
      for (i = 1; i <= m; i++) begin
        run = run * 64'(nn - m + i);
        run = run / 64'(i);
        if (run > 64'hFFFF_FFFF) begin
          res.stat = bc_pkg::STAT_SAT;
          break;
        end
      end
      res.coef = (res.stat == bc_pkg::STAT_SAT) ? '1 : run[bc_pkg::COEF_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    choose_res_t want;
    logic [bc_pkg::COEF_W-1:0] got_coef;
    logic [bc_pkg::STAT_W-1:0] got_stat;
    logic [bc_pkg::OUT_TDATA_W-bc_pkg::COEF_W-bc_pkg::STAT_W-1:0] got_pad;
    int errs;
    errs = fail_cnt;
    if (rst_n) begin
      // result side first: a result never belongs to a transaction taken
      // at the same edge
      if (out_tvalid && out_tready) begin
        got_coef = out_tdata[bc_pkg::COEF_W-1:0];
        got_stat = out_tdata[bc_pkg::COEF_W +: bc_pkg::STAT_W];
        got_pad  = out_tdata[bc_pkg::OUT_TDATA_W-1:bc_pkg::COEF_W+bc_pkg::STAT_W];
        results_seen <= results_seen + 1;
        if (coef_q.size() == 0) begin
          $display("%0t: unexpected result, actual coef=%0d stat=%0d",
                   $time, got_coef, got_stat);
          errs++;
        end else begin
          want = coef_q.pop_front();
          if (got_coef !== want.coef) begin
            $display("%0t: coefficient mismatch, expected %0d actual %0d",
                     $time, want.coef, got_coef);
            errs++;
          end
          if (got_stat !== want.stat) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.stat, got_stat);
            errs++;
          end
          if (got_pad !== '0) begin
            $display("%0t: tdata padding mismatch, expected 0 actual %h",
                     $time, got_pad);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready)
        coef_q.push_back(choose_predict(in_tdata[bc_pkg::N_W-1:0],
                                        in_tdata[2*bc_pkg::N_W-1:bc_pkg::N_W]));
    end
    fail_cnt    <= errs;
    pending_cnt <= coef_q.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top of the binomial coefficient regression
// Drives n/k transactions (directed corners, then random well-formed and
// noise items) with random idle gaps and backpressure, including one long
// output hold-off and one full drain pause; bc_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_RANDOM  = 850;
  localparam int LONG_HOLD   = 3000;     // receiver hold-off, cycles
  localparam int DRAIN_WAIT  = 800;      // margin above the slowest item
  localparam int CYCLE_LIMIT = 4000000;  // far above the slowest legal run
  localparam int PAUSE_AT    = 500;      // random item where input drains

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [bc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bc_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_cnt, pending_cnt, results_seen;
  bit tx_quiet = 1'b0;   // sender stretch with no gaps

  binomial_coefficient u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_cnt     (fail_cnt),
    .pending_cnt  (pending_cnt),
    .results_seen (results_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // single reset at start
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // present one n/k transaction, hold until accepted, then maybe idle.
  // tvalid stays high across back-to-back transactions.
  task automatic offer_nk(input logic [bc_pkg::N_W-1:0] n,
                          input logic [bc_pkg::N_W-1:0] k);
    int unsigned gap;
    in_tdata  <= {4'b0000, k, n};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random stalls, quiet stretches, one long hold-off so the unit
  // fills up (result register plus the item in flight) and drops in_tready
  initial begin : receiver
    int unsigned stall_left;
    bit long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        out_tready    <= 1'b0;
      end else if ((results_seen / 64) % 3 == 1) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = idle_len();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [bc_pkg::N_W-1:0] n, k;
    int unsigned sel;
    do @(posedge clk); while (!rst_n);

    // directed corners: trivial, k = 0 / n, largest served n, first
    // unserved n, k > n (incl. over-range n), all-ones and all-zero fields
    offer_nk(6'd0,  6'd0);
    offer_nk(6'd1,  6'd0);
    offer_nk(6'd1,  6'd1);
    offer_nk(6'd34, 6'd17);
    offer_nk(6'd34, 6'd16);
    offer_nk(6'd34, 6'd18);
    offer_nk(6'd34, 6'd0);
    offer_nk(6'd34, 6'd34);
    offer_nk(6'd33, 6'd16);
    offer_nk(6'd17, 6'd8);
    offer_nk(6'd10, 6'd5);
    offer_nk(6'd20, 6'd3);
    offer_nk(6'd5,  6'd2);
    offer_nk(6'd35, 6'd0);
    offer_nk(6'd35, 6'd35);
    offer_nk(6'd63, 6'd63);
    offer_nk(6'd63, 6'd0);
    offer_nk(6'd63, 6'd31);
    offer_nk(6'd63, 6'd62);
    offer_nk(6'd0,  6'd1);
    offer_nk(6'd0,  6'd63);
    offer_nk(6'd34, 6'd35);
    offer_nk(6'd62, 6'd63);
    offer_nk(6'd21, 6'd42);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      tx_quiet = ((i / 40) % 3 == 2);
      if (i == PAUSE_AT) begin
        // sender holds back until every result is in
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_cnt != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        // well-formed: served n, k within range
        n = bc_pkg::N_W'($urandom_range(0, bc_pkg::MAX_N));
        k = bc_pkg::N_W'($urandom_range(0, n));
      end else begin
        // noise over the full fields
        n = bc_pkg::N_W'($urandom_range(0, 63));
        k = bc_pkg::N_W'($urandom_range(0, 63));
      end
      offer_nk(n, k);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending_cnt != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0 && pending_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bc_pkg.sv
rtl/core/bc_dpath.sv
rtl/core/bc_ctrl.sv
rtl/core/binomial_coefficient.sv
rtl/core/bc_chk.sv
sim/bc_checker.sv
sim/testbench.sv
